>>> hdl/iate_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iate_pkg: shared definitions for the indexed array table engine
// Request codes, status codes, result word layout and default sizes.
// ----------------------------------------------------------------------------
package iate_pkg;

  // default table geometry
  localparam int IATE_DEPTH      = 64;
  localparam int IATE_DATA_WIDTH = 32;

  // capacity register value after reset
  localparam logic [6:0] CAP_RESET = 7'd64;

  // request codes
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_SWAP   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // one result word from the sequencer
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_position;
    logic [31:0] removed_value;
    logic [6:0]  fill_count;
  } res_t;

endpackage

>>> hdl/iate_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iate_ram: entry store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module iate_ram #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/iate_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iate_seq: request sequencer
// Walks the entry store one entry a cycle for shifts and searches and keeps
// the fill count. Shift writes trail the reads by one entry, so a word is
// always read before its place is overwritten.
// ----------------------------------------------------------------------------
module iate_seq
  import iate_pkg::*;
#(
  parameter int DEPTH      = IATE_DEPTH,
  parameter int DATA_WIDTH = IATE_DATA_WIDTH,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            op,
  input  logic [6:0]            position,
  input  logic signed [31:0]    value,
  input  logic [6:0]            capacity,
  output logic                  res_valid,
  input  logic                  res_take,
  output res_t                  res,
  output logic                  we,
  output logic [AW-1:0]         waddr,
  output logic [DATA_WIDTH-1:0] wdata,
  output logic [AW-1:0]         raddr,
  input  logic [DATA_WIDTH-1:0] rdata
);

  localparam int LW = (CW > 7) ? CW : 7;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INS  = 6'b000010,
    S_DEL  = 6'b000100,
    S_SRCH = 6'b001000,
    S_PUT  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                state, state_next;
  logic [CW-1:0]         occ, occ_next;
  logic [CW-1:0]         rd_idx, rd_next;
  logic [AW-1:0]         put_addr, put_next;
  logic [DATA_WIDTH-1:0] e0, e0_next;
  logic [DATA_WIDTH-1:0] word_r, word_in;
  logic [2:0]            op_r;
  logic [CW-1:0]         pos_r;
  logic [1:0]            status_r, status_next;
  logic [5:0]            found_r, found_next;
  logic [31:0]           removed_r, removed_next;

  logic [LW-1:0]         cap_l, dep_l, lim_l, occ_l, pos_l;
  logic                  full;
  logic [CW-1:0]         idx_inc, idx_dec;
  logic [DATA_WIDTH-1:0] e0_val;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign word_in   = DATA_WIDTH'($unsigned(value));

  // limits: capacity saturates at the table depth
  always_comb begin
    cap_l = LW'(capacity);
    dep_l = LW'(DEPTH);
    lim_l = (cap_l > dep_l) ? dep_l : cap_l;
    occ_l = LW'(occ);
    pos_l = LW'(position);
    full  = (occ_l >= lim_l);
  end

  assign idx_inc = rd_idx + CW'(1);
  assign idx_dec = rd_idx - CW'(1);
  assign e0_val  = (rd_idx == '0) ? rdata : e0;

  // next state, store access and result
  always_comb begin
    state_next   = state;
    occ_next     = occ;
    rd_next      = rd_idx;
    put_next     = put_addr;
    e0_next      = e0;
    status_next  = status_r;
    found_next   = found_r;
    removed_next = removed_r;
    we           = 1'b0;
    waddr        = '0;
    wdata        = rdata;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          status_next  = ST_OK;
          found_next   = '0;
          removed_next = '0;
          state_next   = S_DONE;
          case (op)
            OP_APPEND, OP_INSERT: begin
              if (full) begin
                status_next = ST_FULL;
              end else if (op == OP_INSERT && pos_l > occ_l) begin
                status_next = ST_RANGE;
              end else if (op == OP_APPEND || pos_l == occ_l) begin
                // write straight at the end
                we       = 1'b1;
                waddr    = occ[AW-1:0];
                wdata    = word_in;
                occ_next = occ + CW'(1);
              end else begin
                rd_next    = occ - CW'(1);
                state_next = S_INS;
              end
            end
            OP_DELETE: begin
              if (pos_l >= occ_l) begin
                status_next = ST_RANGE;
              end else begin
                rd_next    = CW'(position);
                state_next = S_DEL;
              end
            end
            OP_SEARCH, OP_SWAP: begin
              if (occ == '0) begin
                status_next = ST_NOTFOUND;
              end else begin
                rd_next    = '0;
                state_next = S_SRCH;
              end
            end
            default: begin
              status_next = ST_OK;
            end
          endcase
        end
      end
      S_INS: begin
        // shift up: entry read last cycle moves one place higher
        we    = 1'b1;
        waddr = idx_inc[AW-1:0];
        if (rd_idx > pos_r) begin
          rd_next = idx_dec;
        end else begin
          put_next   = pos_r[AW-1:0];
          state_next = S_PUT;
        end
      end
      S_DEL: begin
        // first read is the removed word, later reads shift down
        if (rd_idx == pos_r) begin
          removed_next = 32'(rdata);
        end else begin
          we    = 1'b1;
          waddr = idx_dec[AW-1:0];
        end
        if (idx_inc < occ) begin
          rd_next = idx_inc;
        end else begin
          occ_next   = occ - CW'(1);
          state_next = S_DONE;
        end
      end
      S_SRCH: begin
        e0_next = e0_val;
        if (rdata == word_r) begin
          if (op_r == OP_SWAP) begin
            // old front word goes to the hit, searched word to the front
            we         = 1'b1;
            waddr      = rd_idx[AW-1:0];
            wdata      = e0_val;
            put_next   = '0;
            state_next = S_PUT;
          end else begin
            found_next = 6'(rd_idx);
            state_next = S_DONE;
          end
        end else if (idx_inc < occ) begin
          rd_next = idx_inc;
        end else begin
          status_next = ST_NOTFOUND;
          state_next  = S_DONE;
        end
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = put_addr;
        wdata = word_r;
        if (op_r == OP_INSERT) begin
          occ_next = occ + CW'(1);
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign raddr = rd_next[AW-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rd_idx    <= rd_next;
    put_addr  <= put_next;
    e0        <= e0_next;
    status_r  <= status_next;
    found_r   <= found_next;
    removed_r <= removed_next;
    if (in_valid && in_ready) begin
      op_r   <= op;
      pos_r  <= CW'(position);
      word_r <= word_in;
    end
  end

  // result word; fill count is already updated when it is shown
  always_comb begin
    res.status         = status_r;
    res.found_position = found_r;
    res.removed_value  = removed_r;
    res.fill_count     = 7'(occ);
  end

endmodule

>>> hdl/indexed_array_table_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_table_engine_unit: packed ordered table with fill count
// Append, insert, delete, search and move-to-front on a table of words.
// ----------------------------------------------------------------------------
// One request is handled at a time. Append, insert at the end, a full table,
// a bad position and unused codes are handled without walking the table.
// Insert below occupancy, delete, search and move-to-front walk the entries
// one by one; the walk is set by the single read port of the entry memory,
// which the sequencer walks one entry per cycle. The result sits in an output
// register, so the next request is taken while the previous result waits. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module indexed_array_table_engine_unit
  import iate_pkg::*;
#(
  parameter int DEPTH      = IATE_DEPTH,
  parameter int DATA_WIDTH = IATE_DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic [6:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [5:0]         found_position,
  output logic signed [31:0] removed_value,
  output logic [6:0]         fill_count
);

  localparam int AW = $clog2(DEPTH);

  logic [6:0]            capacity;
  logic                  res_valid, res_take;
  res_t                  res;
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  iate_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .position  (position),
    .value     (value),
    .capacity  (capacity),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  iate_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // output register: loads when empty or being drained
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status         <= res.status;
      found_position <= res.found_position;
      removed_value  <= res.removed_value;
      fill_count     <= res.fill_count;
    end
  end

endmodule

>>> hdl/iate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iate_checker: port-level checks for the table engine
// Watches the top-level ports; attached by the bind below.
// ----------------------------------------------------------------------------
module iate_checker
  import iate_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [5:0]  found_position,
  input logic [31:0] removed_value,
  input logic [6:0]  fill_count
);

  // after reset the engine is idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("engine not idle after reset");

  // one request at a time: busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a request is in progress");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status)
      && $stable(found_position) && $stable(removed_value) && $stable(fill_count)))
    else $error("result word changed while stalled");

  // failed requests carry no removed word and no match position
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (removed_value == '0 && found_position == '0))
    else $error("failed request reports data");

endmodule

bind indexed_array_table_engine_unit iate_checker u_iate_checker (.*);
